// ===== rtl/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator: item codes, range ops,
// FSM states and the word scan summary struct. No dependencies.
`default_nettype none
package bpfa_pkg;

    localparam int POS_W  = 14;   // page positions, ends of ranges and runs
    localparam int CNT_W  = 13;   // counters, bound, hint
    localparam int IDX_W  = 5;    // bit index inside a bitmap word (up to 32)
    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    localparam logic [2:0] KIND_ALLOC_ONE = 3'd0;
    localparam logic [2:0] KIND_ALLOC_RUN = 3'd1;
    localparam logic [2:0] KIND_FREE      = 3'd2;
    localparam logic [2:0] KIND_LOCK      = 3'd3;
    localparam logic [2:0] KIND_RESERVE   = 3'd4;
    localparam logic [2:0] KIND_UNRESERVE = 3'd5;
    localparam logic [2:0] KIND_CLEAR     = 3'd6;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_OOM  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    typedef enum logic [1:0] {
        OP_FREE,
        OP_LOCK,
        OP_RESERVE,
        OP_UNRESERVE
    } rng_op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_EVAL,
        S_RNG_RD,
        S_RNG_MOD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             blk_any;
        logic [IDX_W-1:0] blk_idx;
        logic             chg_any;
        logic [IDX_W-1:0] chg_idx;
        logic [IDX_W:0]   chg_cnt;
    } word_info_t;

endpackage
`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator_core.sv =====
// Bitmap page frame allocator, top level: sequencer, counters, config,
// output register. Depends on bpfa_pkg, bpfa_bitmap_ram, bpfa_word_ops.
`default_nettype none
// Page frame allocator keeping one busy bit per page in a single-port-read,
// single-port-write RAM of 32-bit words (8-bit words below 32 pages). One
// request is handled at a time and gives one result. Alloc one scans upward
// from the next-fit hint; a run of two or more pages is placed first-fit
// from page 0. Both searches read each word in S_SRCH_RD and evaluate it in
// S_SRCH_EVAL, which may run again for a busy page met inside a word; the
// found run is then marked like a lock range. Range requests (free, lock,
// reserve, unreserve) read each word touched, then write it back. Clear
// and reset both sweep the RAM one word per cycle, during which no request
// is taken; config writes are accepted at any time. Counters saturate at 0
// and 8191. Results sit in an output register, so the next request is
// taken while a result waits on out_stall.
module bitmap_page_frame_allocator_core #(
    parameter int PAGE_LIMIT = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [11:0] first_page,
    input  wire logic [12:0] page_total,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [11:0]      granted_page,
    output logic [12:0]      free_count,
    output logic [12:0]      used_count,
    output logic [12:0]      reserved_count,
    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);

    localparam int POS_W = bpfa_pkg::POS_W;
    localparam int CNT_W = bpfa_pkg::CNT_W;
    localparam int WB    = (PAGE_LIMIT >= 32) ? 32 : 8;
    localparam int LB    = $clog2(WB);
    localparam int DEPTH = (PAGE_LIMIT + WB - 1) / WB;
    localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [bpfa_pkg::IDX_W:0] k);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W + 1)'(k);
        return (s > {1'b0, bpfa_pkg::CNT_MAX}) ? bpfa_pkg::CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] v,
                                                 input logic [bpfa_pkg::IDX_W:0] k);
        return (v < CNT_W'(k)) ? '0 : (v - CNT_W'(k));
    endfunction

    bpfa_pkg::state_t  state_reg, state_next;
    bpfa_pkg::rng_op_t op_reg, op_next;

    logic [CNT_W-1:0] usable_reg;
    logic [CNT_W-1:0] hint_reg, hint_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] resv_reg, resv_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] lim_reg, lim_next;
    logic [POS_W-1:0] run_start_reg, run_start_next;
    logic [POS_W-1:0] run_len_reg, run_len_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic             one_reg, one_next;
    logic             clr_item_reg, clr_item_next;
    logic [DW-1:0]    clr_idx_reg, clr_idx_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [11:0]      res_granted_reg, res_granted_next;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [11:0] out_granted_reg;
    logic [12:0] out_free_reg, out_used_reg, out_resv_reg;

    logic [CNT_W-1:0] bound;
    logic             in_fire, out_fire, load_out;
    logic [POS_W-1:0] base, blk_pos, chg_pos, rng_end, run_sum;
    logic [LB:0]      span;
    logic             run_found;

    logic          mem_rd_en, mem_wr_en;
    logic [DW-1:0] mem_rd_addr, mem_wr_addr;
    logic [WB-1:0] mem_rd_data, mem_wr_data, new_word;
    bpfa_pkg::word_info_t info;

    // effective bound U = min(usable_pages, PAGE_LIMIT)
    assign bound = (32'(usable_reg) > PAGE_LIMIT) ? CNT_W'(PAGE_LIMIT) : usable_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bpfa_pkg::S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign load_out  = (state_reg == bpfa_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    assign base    = pos_reg & ~POS_W'(WB - 1);
    assign blk_pos = base + POS_W'(info.blk_idx[LB-1:0]) + POS_W'(1);
    assign chg_pos = base + POS_W'(info.chg_idx[LB-1:0]);
    assign rng_end = POS_W'(first_page) + POS_W'(page_total);

    // free pages from current position up to the first blocked bit or word end
    assign span = info.blk_any ?
                  ({1'b0, info.blk_idx[LB-1:0]} - {1'b0, pos_reg[LB-1:0]}) :
                  ((LB + 1)'(WB) - {1'b0, pos_reg[LB-1:0]});
    assign run_sum   = run_len_reg + POS_W'(span);
    assign run_found = run_sum >= POS_W'(need_reg);

    bpfa_bitmap_ram #(
        .WB    (WB),
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bpfa_word_ops #(
        .WB (WB)
    ) u_ops (
        .word     (mem_rd_data),
        .base     (base),
        .cur      (pos_reg),
        .lim      (lim_reg),
        .set_bits ((op_reg == bpfa_pkg::OP_LOCK) || (op_reg == bpfa_pkg::OP_RESERVE)),
        .new_word (new_word),
        .info     (info)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpfa_pkg::S_CLEAR:
            begin
                if (clr_idx_reg == DW'(DEPTH - 1))
                begin
                    state_next = clr_item_reg ? bpfa_pkg::S_DONE : bpfa_pkg::S_IDLE;
                end
            end
            bpfa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (kind == bpfa_pkg::KIND_CLEAR)
                        state_next = bpfa_pkg::S_CLEAR;
                    else if ((kind == bpfa_pkg::KIND_ALLOC_ONE) ||
                             ((kind == bpfa_pkg::KIND_ALLOC_RUN) && (page_total == 13'd1)))
                        state_next = (hint_reg >= bound) ? bpfa_pkg::S_DONE
                                                         : bpfa_pkg::S_SRCH_RD;
                    else if (kind == bpfa_pkg::KIND_ALLOC_RUN)
                        state_next = (page_total == 13'd0) ? bpfa_pkg::S_DONE
                                                           : bpfa_pkg::S_SRCH_RD;
                    else if ((kind == bpfa_pkg::KIND_FREE) || (kind == bpfa_pkg::KIND_LOCK) ||
                             (kind == bpfa_pkg::KIND_RESERVE) ||
                             (kind == bpfa_pkg::KIND_UNRESERVE))
                        state_next = bpfa_pkg::S_RNG_RD;
                    else
                        state_next = bpfa_pkg::S_DONE;
                end
            end
            bpfa_pkg::S_SRCH_RD:
            begin
                state_next = (pos_reg >= lim_reg) ? bpfa_pkg::S_DONE : bpfa_pkg::S_SRCH_EVAL;
            end
            bpfa_pkg::S_SRCH_EVAL:
            begin
                if (run_found)
                    state_next = bpfa_pkg::S_RNG_RD;
                else if (!info.blk_any || (blk_pos[LB-1:0] == '0) || (blk_pos >= lim_reg))
                    state_next = bpfa_pkg::S_SRCH_RD;
                else
                    state_next = bpfa_pkg::S_SRCH_EVAL;
            end
            bpfa_pkg::S_RNG_RD:
            begin
                state_next = (pos_reg >= lim_reg) ? bpfa_pkg::S_DONE : bpfa_pkg::S_RNG_MOD;
            end
            bpfa_pkg::S_RNG_MOD:
            begin
                state_next = bpfa_pkg::S_RNG_RD;
            end
            bpfa_pkg::S_DONE:
            begin
                if (load_out)
                    state_next = bpfa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bpfa_pkg::S_IDLE;
            end
        endcase
    end

    // RAM control; each word is read in S_RNG_RD, then written back in S_RNG_MOD, so
    // a read never meets a pending write to the same word
    always_comb
    begin
        mem_rd_en   = ((state_reg == bpfa_pkg::S_SRCH_RD) || (state_reg == bpfa_pkg::S_RNG_RD))
                      && (pos_reg < lim_reg);
        mem_rd_addr = DW'(pos_reg >> LB);
        mem_wr_en   = (state_reg == bpfa_pkg::S_CLEAR) || (state_reg == bpfa_pkg::S_RNG_MOD);
        mem_wr_addr = (state_reg == bpfa_pkg::S_CLEAR) ? clr_idx_reg : DW'(pos_reg >> LB);
        mem_wr_data = (state_reg == bpfa_pkg::S_CLEAR) ? '0 : new_word;
    end

    // datapath
    always_comb
    begin
        op_next          = op_reg;
        hint_next        = hint_reg;
        free_next        = free_reg;
        used_next        = used_reg;
        resv_next        = resv_reg;
        pos_next         = pos_reg;
        lim_next         = lim_reg;
        run_start_next   = run_start_reg;
        run_len_next     = run_len_reg;
        need_next        = need_reg;
        one_next         = one_reg;
        clr_item_next    = clr_item_reg;
        clr_idx_next     = clr_idx_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;

        unique case (state_reg)
            bpfa_pkg::S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + DW'(1);
            end
            bpfa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next  = bpfa_pkg::STAT_DONE;
                    res_granted_next = '0;
                    run_len_next     = '0;
                    unique case (kind)
                        bpfa_pkg::KIND_ALLOC_ONE, bpfa_pkg::KIND_ALLOC_RUN:
                        begin
                            lim_next = POS_W'(bound);
                            op_next  = bpfa_pkg::OP_LOCK;
                            if ((kind == bpfa_pkg::KIND_ALLOC_ONE) || (page_total == 13'd1))
                            begin
                                one_next       = 1'b1;
                                need_next      = 13'd1;
                                pos_next       = POS_W'(hint_reg);
                                run_start_next = POS_W'(hint_reg);
                                if (hint_reg >= bound)
                                    res_status_next = bpfa_pkg::STAT_OOM;
                            end
                            else
                            begin
                                one_next       = 1'b0;
                                need_next      = page_total;
                                pos_next       = '0;
                                run_start_next = '0;
                                if (page_total == 13'd0)
                                    res_status_next = bpfa_pkg::STAT_ZERO;
                            end
                        end
                        bpfa_pkg::KIND_FREE, bpfa_pkg::KIND_LOCK,
                        bpfa_pkg::KIND_RESERVE, bpfa_pkg::KIND_UNRESERVE:
                        begin
                            pos_next = POS_W'(first_page);
                            lim_next = (rng_end < POS_W'(bound)) ? rng_end : POS_W'(bound);
                            unique case (kind)
                                bpfa_pkg::KIND_FREE:    op_next = bpfa_pkg::OP_FREE;
                                bpfa_pkg::KIND_LOCK:    op_next = bpfa_pkg::OP_LOCK;
                                bpfa_pkg::KIND_RESERVE: op_next = bpfa_pkg::OP_RESERVE;
                                default:                op_next = bpfa_pkg::OP_UNRESERVE;
                            endcase
                        end
                        bpfa_pkg::KIND_CLEAR:
                        begin
                            clr_item_next = 1'b1;
                            clr_idx_next  = '0;
                            hint_next     = '0;
                            free_next     = bound;
                            used_next     = '0;
                            resv_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bpfa_pkg::S_SRCH_RD:
            begin
                if (pos_reg >= lim_reg)
                begin
                    // no fitting run below the bound
                    res_status_next = bpfa_pkg::STAT_OOM;
                    if (one_reg)
                        hint_next = bound;
                end
            end
            bpfa_pkg::S_SRCH_EVAL:
            begin
                if (run_found)
                begin
                    // mark the run through the range path
                    pos_next         = run_start_reg;
                    lim_next         = run_start_reg + POS_W'(need_reg);
                    res_granted_next = run_start_reg[11:0];
                    if (one_reg)
                        hint_next = run_start_reg[CNT_W-1:0];
                end
                else if (info.blk_any)
                begin
                    run_start_next = blk_pos;
                    run_len_next   = '0;
                    pos_next       = blk_pos;
                end
                else
                begin
                    run_len_next = run_sum;
                    pos_next     = base + POS_W'(WB);
                end
            end
            bpfa_pkg::S_RNG_RD:
            begin
            end
            bpfa_pkg::S_RNG_MOD:
            begin
                pos_next = base + POS_W'(WB);
                unique case (op_reg)
                    bpfa_pkg::OP_LOCK:
                    begin
                        free_next = sat_sub(free_reg, info.chg_cnt);
                        used_next = sat_add(used_reg, info.chg_cnt);
                    end
                    bpfa_pkg::OP_RESERVE:
                    begin
                        free_next = sat_sub(free_reg, info.chg_cnt);
                        resv_next = sat_add(resv_reg, info.chg_cnt);
                    end
                    bpfa_pkg::OP_FREE:
                    begin
                        free_next = sat_add(free_reg, info.chg_cnt);
                        used_next = sat_sub(used_reg, info.chg_cnt);
                    end
                    default:
                    begin
                        free_next = sat_add(free_reg, info.chg_cnt);
                        resv_next = sat_sub(resv_reg, info.chg_cnt);
                    end
                endcase
                // a released page pulls the next-fit hint down
                if (((op_reg == bpfa_pkg::OP_FREE) || (op_reg == bpfa_pkg::OP_UNRESERVE)) &&
                    info.chg_any && (POS_W'(hint_reg) > chg_pos))
                    hint_next = chg_pos[CNT_W-1:0];
            end
            bpfa_pkg::S_DONE:
            begin
                clr_item_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bpfa_pkg::S_CLEAR;
            usable_reg   <= 13'd4096;
            hint_reg     <= '0;
            free_reg     <= '0;
            used_reg     <= '0;
            resv_reg     <= '0;
            clr_item_reg <= 1'b0;
            clr_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hint_reg     <= hint_next;
            free_reg     <= free_next;
            used_reg     <= used_next;
            resv_reg     <= resv_next;
            clr_item_reg <= clr_item_next;
            clr_idx_reg  <= clr_idx_next;
            if (cfg_valid && cfg_ready)
                usable_reg <= cfg_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        pos_reg         <= pos_next;
        lim_reg         <= lim_next;
        run_start_reg   <= run_start_next;
        run_len_reg     <= run_len_next;
        need_reg        <= need_next;
        one_reg         <= one_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        if (load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_free_reg    <= free_reg;
            out_used_reg    <= used_reg;
            out_resv_reg    <= resv_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_page   = out_granted_reg;
    assign free_count     = out_free_reg;
    assign used_count     = out_used_reg;
    assign reserved_count = out_resv_reg;

`ifndef ASSERT_OFF
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bpfa_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr)))
        else $error("bitmap read and write of one word in the same cycle");

    a_run_below_need: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpfa_pkg::S_SRCH_EVAL) |-> (run_len_reg < POS_W'(need_reg)))
        else $error("run length reached request size without a grant");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpfa_pkg::S_CLEAR) |-> in_stall)
        else $error("request taken during bitmap clearing pass");
`endif

endmodule
`default_nettype wire

// ===== rtl/bpfa_bitmap_ram.sv =====
// Busy bitmap storage: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none
module bpfa_bitmap_ram #(
    parameter int WB    = 32,
    parameter int DEPTH = 128,
    parameter int DW    = 7
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [DW-1:0] rd_addr,
    output logic      [WB-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [DW-1:0] wr_addr,
    input  wire logic [WB-1:0] wr_data
);

    logic [WB-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bpfa_word_ops.sv =====
// Per-word logic: range mask, modified word, changed-bit count and lowest
// changed / blocked bit. Depends on bpfa_pkg.
`default_nettype none
module bpfa_word_ops #(
    parameter int WB = 32
) (
    input  wire logic [WB-1:0]             word,
    input  wire logic [bpfa_pkg::POS_W-1:0] base,
    input  wire logic [bpfa_pkg::POS_W-1:0] cur,
    input  wire logic [bpfa_pkg::POS_W-1:0] lim,
    input  wire logic                      set_bits,
    output logic      [WB-1:0]             new_word,
    output bpfa_pkg::word_info_t           info
);

    logic [WB-1:0] in_rng;
    logic [WB-1:0] blocked;
    logic [WB-1:0] chg;

    // page in [cur, lim) is in range; at or past cur and busy or out of bound blocks
    always_comb
    begin
        for (int b = 0; b < WB; b++)
        begin
            in_rng[b]  = (base + bpfa_pkg::POS_W'(b) >= cur) &&
                         (base + bpfa_pkg::POS_W'(b) <  lim);
            blocked[b] = (base + bpfa_pkg::POS_W'(b) >= cur) &&
                         (word[b] || (base + bpfa_pkg::POS_W'(b) >= lim));
        end
    end

    assign chg      = set_bits ? (in_rng & ~word) : (in_rng & word);
    assign new_word = set_bits ? (word | in_rng)  : (word & ~in_rng);

    always_comb
    begin
        info.blk_any = |blocked;
        info.chg_any = |chg;
        info.blk_idx = '0;
        info.chg_idx = '0;
        info.chg_cnt = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (blocked[b])
            begin
                info.blk_idx = bpfa_pkg::IDX_W'(b);
            end
            if (chg[b])
            begin
                info.chg_idx = bpfa_pkg::IDX_W'(b);
            end
        end
        for (int b = 0; b < WB; b++)
        begin
            info.chg_cnt = info.chg_cnt + (bpfa_pkg::IDX_W + 1)'(chg[b]);
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for bitmap_page_frame_allocator_core: directed and random requests,
// a bit-exact allocator predictor and a small scoreboard class.
// Depends on rtl/bpfa_pkg.sv and the allocator RTL.
`default_nettype none
module tb;
    import bpfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES = 4096;
    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] granted;
        logic [12:0] free_n;
        logic [12:0] used_n;
        logic [12:0] rsv_n;
    } alloc_result_t;

    int unsigned fail_count = 0;
    int unsigned result_count = 0;

    // One line per mismatch, counted toward the final verdict.
    task automatic report(input string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Scoreboard: owns the allocator shadow state and the queue of pending results.
    class alloc_scoreboard;
        bit            busy[NPAGES];
        int unsigned   hint, free_n, used_n, rsv_n, usable;
        alloc_result_t pending[$];

        function void init();
            foreach (busy[i]) busy[i] = 0;
            hint = 0; free_n = 0; used_n = 0; rsv_n = 0; usable = 4096;
        endfunction

        function int unsigned limit();
            return usable < NPAGES ? usable : NPAGES;
        endfunction

        function void set_usable(int unsigned v);
            usable = v;
        endfunction

        function void mark(int unsigned p, rng_op_t op);
            if (p >= limit()) return;
            if (op == OP_LOCK || op == OP_RESERVE) begin
                if (busy[p]) return;
                busy[p] = 1;
                free_n = free_n ? free_n - 1 : 0;
                if (op == OP_LOCK) used_n = used_n < 8191 ? used_n + 1 : 8191;
                else rsv_n = rsv_n < 8191 ? rsv_n + 1 : 8191;
            end else begin
                if (!busy[p]) return;
                busy[p] = 0;
                free_n = free_n < 8191 ? free_n + 1 : 8191;
                if (op == OP_FREE) used_n = used_n ? used_n - 1 : 0;
                else rsv_n = rsv_n ? rsv_n - 1 : 0;
                if (hint > p) hint = p;
            end
        endfunction

        function bit grab_one(output int unsigned pg);
            for (; hint < limit(); hint++)
                if (!busy[hint]) begin
                    mark(hint, OP_LOCK);
                    pg = hint;
                    return 1;
                end
            return 0;
        endfunction

        function bit grab_run(int unsigned n, output int unsigned pg);
            int unsigned u;
            bit fits;
            u = limit();
            for (int unsigned i = 0; i < u; i++) begin
                fits = 1;
                for (int unsigned j = 0; j < n; j++)
                    if (i + j >= u || busy[i + j]) begin
                        fits = 0;
                        i += j;
                        break;
                    end
                if (fits) begin
                    for (int unsigned j = 0; j < n; j++) mark(i + j, OP_LOCK);
                    pg = i;
                    return 1;
                end
            end
            return 0;
        endfunction

        // Accepted request: update shadow state and queue the expected result.
        function void note_request(logic [2:0] k, logic [11:0] fp, logic [12:0] n);
            alloc_result_t r;
            int unsigned pg;
            r = '0;
            r.status = STAT_DONE;
            pg = 0;
            case (k)
                KIND_ALLOC_ONE:
                    if (grab_one(pg)) r.granted = pg[11:0]; else r.status = STAT_OOM;
                KIND_ALLOC_RUN:
                    if (n == 0) r.status = STAT_ZERO;
                    else if (n == 1) begin
                        if (grab_one(pg)) r.granted = pg[11:0]; else r.status = STAT_OOM;
                    end else begin
                        if (grab_run(n, pg)) r.granted = pg[11:0]; else r.status = STAT_OOM;
                    end
                KIND_FREE, KIND_LOCK, KIND_RESERVE, KIND_UNRESERVE:
                    for (int unsigned t = 0; t < n; t++)
                        mark(fp + t, rng_op_t'(k - KIND_FREE));
                KIND_CLEAR: begin
                    foreach (busy[i]) busy[i] = 0;
                    hint = 0; free_n = limit(); used_n = 0; rsv_n = 0;
                end
                default: ;
            endcase
            r.free_n = 13'(free_n);
            r.used_n = 13'(used_n);
            r.rsv_n = 13'(rsv_n);
            pending.push_back(r);
        endfunction

        task check_result(alloc_result_t got);
            alloc_result_t e;
            if (pending.size() == 0) begin
                report("result with no request pending");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.granted !== e.granted)
                report($sformatf("granted_page %0d, want %0d", got.granted, e.granted));
            if (got.free_n !== e.free_n)
                report($sformatf("free_count %0d, want %0d", got.free_n, e.free_n));
            if (got.used_n !== e.used_n)
                report($sformatf("used_count %0d, want %0d", got.used_n, e.used_n));
            if (got.rsv_n !== e.rsv_n)
                report($sformatf("reserved_count %0d, want %0d", got.rsv_n, e.rsv_n));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [11:0] first_page = '0;
    logic [12:0] page_total = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  status;
    logic [11:0] granted_page;
    logic [12:0] free_count, used_count, reserved_count;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;

    alloc_scoreboard board = new();
    int unsigned sent = 0;
    int unsigned burst_left = 0;
    bit          stall_bias = 0;

    always #5 clk = ~clk;

    bitmap_page_frame_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .first_page(first_page), .page_total(page_total),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_page(granted_page),
        .free_count(free_count), .used_count(used_count),
        .reserved_count(reserved_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Receiver side: stall pattern switches between quiet and busy phases,
    // and every accepted result goes to the scoreboard.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                board.check_result({status, granted_page, free_count, used_count,
                                    reserved_count});
                result_count++;
            end
            if ($urandom_range(0, 63) == 0) stall_bias <= ~stall_bias;
            out_stall <= stall_bias ? ($urandom_range(0, 3) != 0) : 1'b0;
        end
    end

    // Send one request; bursts of back-to-back requests separated by random gaps.
    task automatic send_req(input logic [2:0] k, input logic [11:0] fp,
                            input logic [12:0] n);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind <= k;
        first_page <= fp;
        page_total <= n;
        do @(posedge clk); while (in_stall);
        board.note_request(k, fp, n);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        // no request is ever in flight without a result; short margin anyway
        repeat (4) @(posedge clk);
    endtask

    task automatic write_usable(input logic [12:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_usable(v);
    endtask

    // Mostly sensible traffic near the current bound: allocations, ranges
    // over the active area, an occasional clear, and some wide noise.
    task automatic random_req(input int unsigned u);
        int unsigned sel, span;
        logic [11:0] fp;
        logic [12:0] n;
        span = u > 1 ? u : 2;
        sel = $urandom_range(0, 99);
        fp = 12'($urandom_range(0, span - 1));
        n = $urandom_range(0, 3) == 0 ? 13'($urandom_range(0, 8191))
                                       : 13'($urandom_range(0, span / 4 + 2));
        if ($urandom_range(0, 15) == 0) fp = 12'($urandom_range(0, 4095));
        if (sel < 30)      send_req(KIND_ALLOC_ONE, 12'($urandom_range(0, 4095)), n);
        else if (sel < 50) send_req(KIND_ALLOC_RUN, fp, $urandom_range(0, 9) ? n % 40 : n);
        else if (sel < 65) send_req(KIND_FREE, fp, n);
        else if (sel < 73) send_req(KIND_LOCK, fp, n);
        else if (sel < 81) send_req(KIND_RESERVE, fp, n);
        else if (sel < 92) send_req(KIND_UNRESERVE, fp, n);
        else if (sel < 97) send_req(KIND_CLEAR, fp, n);
        else               send_req(KIND_UNKNOWN, fp, n);
    endtask

    initial begin
        logic [12:0] sizes[6];
        sizes = '{13'd4096, 13'd1, 13'd40, 13'd200, 13'd0, 13'd8191};
        board.init();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: counters before clear, clear, extremes of every kind.
        send_req(KIND_ALLOC_ONE, 12'd0, 13'd0);
        send_req(KIND_CLEAR, 12'hFFF, 13'h1FFF);
        send_req(KIND_ALLOC_ONE, 12'd0, 13'd0);
        send_req(KIND_ALLOC_RUN, 12'd0, 13'd0);       // zero-length run
        send_req(KIND_ALLOC_RUN, 12'd0, 13'd1);       // run of one behaves as single
        send_req(KIND_ALLOC_RUN, 12'd0, 13'd5);
        send_req(KIND_LOCK, 12'd10, 13'd3);
        send_req(KIND_ALLOC_RUN, 12'd0, 13'd6);       // skips past blocking page
        send_req(KIND_RESERVE, 12'd4090, 13'd100);    // runs off the bound
        send_req(KIND_LOCK, 12'd10, 13'd3);           // already busy, no count moves
        send_req(KIND_FREE, 12'd0, 13'd2);            // lowers the hint
        send_req(KIND_ALLOC_ONE, 12'd0, 13'd0);
        send_req(KIND_UNRESERVE, 12'd4090, 13'd6);
        send_req(KIND_UNRESERVE, 12'd10, 13'd1);      // unreserve of a locked page
        send_req(KIND_FREE, 12'd0, 13'd0);
        send_req(KIND_ALLOC_RUN, 12'd0, 13'h1FFF);    // out of memory
        send_req(KIND_UNKNOWN, 12'hFFF, 13'h1FFF);    // unknown kind
        send_req(KIND_LOCK, 12'd0, 13'd4096);         // whole map
        send_req(KIND_ALLOC_ONE, 12'd0, 13'd0);       // full map, hint runs to bound
        send_req(KIND_FREE, 12'hFFF, 13'd1);
        send_req(KIND_ALLOC_ONE, 12'd0, 13'd0);
        send_req(KIND_FREE, 12'd0, 13'h1FFF);
        settle();

        // Phases over several bounds, each starting with a clear.
        for (int ph = 0; ph < 6; ph++) begin
            write_usable(sizes[ph]);
            send_req(KIND_CLEAR, 12'd0, 13'd0);
            send_req(KIND_ALLOC_ONE, 12'd0, 13'd0);
            send_req(KIND_ALLOC_RUN, 12'd0, 13'd2);
            for (int i = 0; i < 150; i++)
                random_req(sizes[ph] > 4096 ? 4096 : sizes[ph]);
            settle();
        end
        write_usable(13'd64);
        for (int i = 0; i < 30; i++) random_req(64);
        settle();
        repeat (20) @(posedge clk);

        $display("Run covered %0d requests and %0d checked results over six page bounds.",
                 sent, result_count);
        if (fail_count == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #250ms;
        $display("Timeout waiting for the allocator");
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/bpfa_pkg.sv
rtl/bpfa_bitmap_ram.sv
rtl/bpfa_word_ops.sv
rtl/bitmap_page_frame_allocator_core.sv
sim/tb.sv
